### hdl/onewire_temperature_reader_unit_macros.svh
// Assertion macros shared by the checker file.
`ifndef ONEWIRE_TEMPERATURE_READER_UNIT_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define OWTR_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define OWTR_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/owtr_pkg.sv
// ---------------------------------------------------------------------------
// owtr_pkg
// Types and constants of the one-wire temperature reader.
// ---------------------------------------------------------------------------
package owtr_pkg;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_REL   = 4'd1,
        PH_RST_LOW   = 4'd2,
        PH_RST_WAIT  = 4'd3,
        PH_POLL      = 4'd4,
        PH_PRES_WAIT = 4'd5,
        PH_WR_SKIP   = 4'd6,
        PH_WR_CMD    = 4'd7,
        PH_CONV_WAIT = 4'd8,
        PH_READ      = 4'd9
    } phase_t;

    // Outcome codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_CRC_ERROR   = 2'd2
    } status_t;

    // Register indexes
    localparam logic REG_RESET_LOW = 1'b0;
    localparam logic REG_CONV_WAIT = 1'b1;

    localparam logic [9:0]  RESET_LOW_DEFAULT = 10'd700;
    localparam logic [19:0] CONV_WAIT_DEFAULT = 20'd750000;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    // Span lengths in ticks
    localparam logic [20:0] LEN_REL     = 21'd10;
    localparam logic [20:0] LEN_WAIT    = 21'd60;
    localparam logic [20:0] LEN_POLL    = 21'd10;
    localparam logic [20:0] LEN_PRES    = 21'd480;
    localparam logic [20:0] LEN_WR_SLOT = 21'd78;
    localparam logic [20:0] LEN_RD_SLOT = 21'd62;
    localparam logic [19:0] WR_LOW_END  = 20'd8;
    localparam logic [19:0] WR_DATA_END = 20'd68;
    localparam logic [19:0] RD_SAMPLE   = 20'd2;
    localparam logic [4:0]  POLL_MAX    = 5'd20;

    localparam int         SCRATCH_BYTES = 9;
    localparam logic [3:0] SCRATCH_LAST  = 4'(SCRATCH_BYTES - 1);

    // Scale of one raw LSB (1/16 degree) in units of 1e-4 degree
    localparam logic [20:0] TEMP_SCALE = 21'(10000 / 16);

endpackage

### hdl/onewire_temperature_reader_unit.sv
// ---------------------------------------------------------------------------
// onewire_temperature_reader_unit
// One-wire bus master that runs a full temperature measurement, one word
// per microsecond tick.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one word per microsecond tick: start request and
//   sampled line level. Each accepted word advances the sequencer by one
//   tick and produces exactly one m_ word: line drive, busy, done, status
//   and temperature (valid on the done word).
//   The m_ word of an accepted s_ word is registered. A new word is
//   taken every cycle while s_tready is high; the whole tick is one pass
//   of logic between the state registers and the output register.
//   The output register holds a word while m_tready is low; s_tready then
//   drops until that word is taken, and it rises again in the same cycle
//   the receiver takes it.
//   Reset (aresetn low, synchronous) returns the sequencer to idle, empties
//   the output register and loads the default timing registers
//   (reset pulse 700 ticks, conversion wait 750000 ticks).
//   The APB port writes the timing registers at 0x0 and 0x4; write them
//   only while no measurement runs.
// ---------------------------------------------------------------------------
module onewire_temperature_reader_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] line_high, [7:2] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [4:3] status, [25:5] temperature, [31:26] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [9:0]  reset_low_reg;
    logic [19:0] conv_wait_reg;

    // Sequencer state
    owtr_pkg::phase_t phase_reg, phase_next;
    logic [19:0] tick_reg, tick_next;
    logic [4:0]  poll_reg, poll_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  byte_reg, byte_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  temp_low_reg, temp_low_next;
    logic [7:0]  temp_high_reg, temp_high_next;
    logic        second_reg, second_next;

    // Output register
    logic        m_valid_reg;
    logic [31:0] m_data_reg, m_data_next;

    logic s_accept;
    logic start_req, line_high;

    // Tick working signals
    owtr_pkg::phase_t ph_eff;
    logic [19:0] t_eff;
    logic [20:0] tick_inc;
    logic [20:0] span_len;
    logic        span_hit;
    logic [7:0]  cmd;
    logic        cmd_bit;
    logic        drive, done;
    owtr_pkg::status_t status;
    logic [20:0] temp;
    logic [15:0] raw;

    assign start_req = s_tdata[0];
    assign line_high = s_tdata[1];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;

    // Register read mux
    always_comb begin
        if (paddr[2] == owtr_pkg::REG_CONV_WAIT) begin
            prdata = {12'd0, conv_wait_reg};
        end else begin
            prdata = {22'd0, reset_low_reg};
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg <= owtr_pkg::RESET_LOW_DEFAULT;
            conv_wait_reg <= owtr_pkg::CONV_WAIT_DEFAULT;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == owtr_pkg::REG_CONV_WAIT) begin
                conv_wait_reg <= pwdata[19:0];
            end else begin
                reset_low_reg <= pwdata[9:0];
            end
        end
    end

    // Start decision and span timer
    always_comb begin
        ph_eff = phase_reg;
        t_eff  = tick_reg;
        if (phase_reg == owtr_pkg::PH_IDLE && start_req) begin
            ph_eff = owtr_pkg::PH_RST_REL;
            t_eff  = 20'd0;
        end
        tick_inc = {1'b0, t_eff} + 21'd1;
        unique case (ph_eff)
            owtr_pkg::PH_RST_REL:   span_len = owtr_pkg::LEN_REL;
            owtr_pkg::PH_RST_LOW:   span_len = {11'd0, reset_low_reg};
            owtr_pkg::PH_RST_WAIT:  span_len = owtr_pkg::LEN_WAIT;
            owtr_pkg::PH_POLL:      span_len = owtr_pkg::LEN_POLL;
            owtr_pkg::PH_PRES_WAIT: span_len = owtr_pkg::LEN_PRES;
            owtr_pkg::PH_WR_SKIP,
            owtr_pkg::PH_WR_CMD:    span_len = owtr_pkg::LEN_WR_SLOT;
            owtr_pkg::PH_CONV_WAIT: span_len = {1'b0, conv_wait_reg};
            owtr_pkg::PH_READ:      span_len = owtr_pkg::LEN_RD_SLOT;
            default:                span_len = 21'd0;
        endcase
        span_hit = tick_inc >= span_len;

        // command bit for write slots
        if (ph_eff == owtr_pkg::PH_WR_SKIP) begin
            cmd = owtr_pkg::CMD_SKIP_ROM;
        end else if (second_reg) begin
            cmd = owtr_pkg::CMD_READ_SP;
        end else begin
            cmd = owtr_pkg::CMD_CONVERT;
        end
        cmd_bit = cmd[bit_reg];
    end

    // Next state of the sequencer
    always_comb begin
        phase_next     = ph_eff;
        tick_next      = t_eff;
        poll_next      = poll_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        temp_low_next  = temp_low_reg;
        temp_high_next = temp_high_reg;
        second_next    = second_reg;
        if (phase_reg == owtr_pkg::PH_IDLE && start_req) begin
            second_next = 1'b0;
        end
        if (ph_eff != owtr_pkg::PH_IDLE) begin
            tick_next = span_hit ? 20'd0 : tick_inc[19:0];
        end
        unique case (ph_eff)
            owtr_pkg::PH_RST_REL: begin
                if (span_hit) phase_next = owtr_pkg::PH_RST_LOW;
            end
            owtr_pkg::PH_RST_LOW: begin
                if (span_hit) phase_next = owtr_pkg::PH_RST_WAIT;
            end
            owtr_pkg::PH_RST_WAIT: begin
                if (span_hit) begin
                    phase_next = owtr_pkg::PH_POLL;
                    poll_next  = 5'd0;
                end
            end
            owtr_pkg::PH_POLL: begin
                if (span_hit) begin
                    if (!line_high) begin
                        phase_next = owtr_pkg::PH_PRES_WAIT;
                    end else begin
                        poll_next = poll_reg + 5'd1;
                        if (poll_next >= owtr_pkg::POLL_MAX) begin
                            phase_next = owtr_pkg::PH_IDLE;
                        end
                    end
                end
            end
            owtr_pkg::PH_PRES_WAIT: begin
                if (span_hit) begin
                    phase_next = owtr_pkg::PH_WR_SKIP;
                    bit_next   = 3'd0;
                end
            end
            owtr_pkg::PH_WR_SKIP,
            owtr_pkg::PH_WR_CMD: begin
                if (span_hit) begin
                    if (bit_reg == 3'd7) begin
                        bit_next = 3'd0;
                        if (ph_eff == owtr_pkg::PH_WR_SKIP) begin
                            phase_next = owtr_pkg::PH_WR_CMD;
                        end else if (second_reg) begin
                            phase_next = owtr_pkg::PH_READ;
                            byte_next  = 4'd0;
                            shift_next = 8'd0;
                            crc_next   = 8'd0;
                        end else begin
                            phase_next = owtr_pkg::PH_CONV_WAIT;
                        end
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            owtr_pkg::PH_CONV_WAIT: begin
                if (span_hit) begin
                    second_next = 1'b1;
                    phase_next  = owtr_pkg::PH_RST_REL;
                end
            end
            owtr_pkg::PH_READ: begin
                // sample point of the read slot
                if (t_eff == owtr_pkg::RD_SAMPLE) begin
                    shift_next = {line_high, shift_reg[7:1]};
                    if (byte_reg < owtr_pkg::SCRATCH_LAST) begin
                        crc_next = {1'b0, crc_reg[7:1]}
                                 ^ ((crc_reg[0] ^ line_high) ? owtr_pkg::CRC_POLY : 8'd0);
                    end
                end
                if (span_hit) begin
                    if (bit_reg == 3'd7) begin
                        bit_next = 3'd0;
                        if (byte_reg == 4'd0) temp_low_next = shift_next;
                        if (byte_reg == 4'd1) temp_high_next = shift_next;
                        if (byte_reg >= owtr_pkg::SCRATCH_LAST) begin
                            phase_next = owtr_pkg::PH_IDLE;
                        end else begin
                            byte_next = byte_reg + 4'd1;
                        end
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            default: begin
                phase_next = owtr_pkg::PH_IDLE;
            end
        endcase
    end

    // Result word of this tick
    always_comb begin
        drive  = 1'b0;
        done   = 1'b0;
        status = owtr_pkg::ST_OK;
        temp   = 21'd0;
        raw    = {temp_high_next, temp_low_next};
        unique case (ph_eff)
            owtr_pkg::PH_RST_LOW: drive = 1'b1;
            owtr_pkg::PH_POLL: begin
                if (span_hit && line_high && poll_next >= owtr_pkg::POLL_MAX) begin
                    done   = 1'b1;
                    status = owtr_pkg::ST_NO_PRESENCE;
                end
            end
            owtr_pkg::PH_WR_SKIP,
            owtr_pkg::PH_WR_CMD: begin
                drive = (t_eff < owtr_pkg::WR_LOW_END)
                     || (t_eff < owtr_pkg::WR_DATA_END && !cmd_bit);
            end
            owtr_pkg::PH_READ: begin
                drive = (t_eff == 20'd0);
                if (span_hit && bit_reg == 3'd7 && byte_reg >= owtr_pkg::SCRATCH_LAST) begin
                    done = 1'b1;
                    if (crc_next != shift_next || crc_next == 8'd0) begin
                        status = owtr_pkg::ST_CRC_ERROR;
                    end else if (raw[15:12] == 4'd0) begin
                        temp = 21'(raw[10:0]) * owtr_pkg::TEMP_SCALE;
                    end
                end
            end
            default: ;
        endcase
        m_data_next = {6'd0, temp, status, done,
                       (phase_next != owtr_pkg::PH_IDLE), drive};
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= owtr_pkg::PH_IDLE;
            tick_reg      <= 20'd0;
            poll_reg      <= 5'd0;
            bit_reg       <= 3'd0;
            byte_reg      <= 4'd0;
            shift_reg     <= 8'd0;
            crc_reg       <= 8'd0;
            temp_low_reg  <= 8'd0;
            temp_high_reg <= 8'd0;
            second_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (s_accept) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            poll_reg      <= poll_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            shift_reg     <= shift_next;
            crc_reg       <= crc_next;
            temp_low_reg  <= temp_low_next;
            temp_high_reg <= temp_high_next;
            second_reg    <= second_next;
            m_valid_reg   <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

### hdl/owtr_checker.sv
// ---------------------------------------------------------------------------
// owtr_checker
// Port-level checks of the one-wire temperature reader, bound to the top.
// ---------------------------------------------------------------------------
`include "onewire_temperature_reader_unit_macros.svh"

module owtr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // stalled word holds
    `OWTR_ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
    // finishing word reports idle
    `OWTR_ASSERT_RST(a_done_idle, aclk, aresetn, m_tvalid && m_tdata[2] |-> !m_tdata[1], "done word reports busy")
    // status and temperature only on the done word
    `OWTR_ASSERT_RST(a_quiet, aclk, aresetn, m_tvalid && !m_tdata[2] |-> m_tdata[25:3] == 23'd0, "status or temperature outside done")
    // no undefined status code, no temperature with bad status
    `OWTR_ASSERT_RST(a_status, aclk, aresetn, m_tvalid && m_tdata[4:3] != 2'd0 |-> m_tdata[4:3] != 2'd3 && m_tdata[25:5] == 21'd0, "bad status code or temperature with error")
    // reset empties the output
    `OWTR_ASSERT(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind onewire_temperature_reader_unit owtr_checker u_owtr_checker (.*);
